@@ src/cpvc_pkg.sv @@
// Shared types and constants of the cascaded PI voltage/current controller.
package cpvc_pkg;

    localparam int DATA_W   = 16;
    localparam int GAIN_W   = 24;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 5;
    localparam int REG_IDXW = 3;

    typedef enum logic [REG_IDXW-1:0] {
        REG_KP_V,
        REG_KI_V,
        REG_KP_I,
        REG_KI_I,
        REG_REF_MIN,
        REG_REF_MAX,
        REG_DUTY_MIN,
        REG_DUTY_MAX
    } cpvc_reg_t;

    typedef enum logic [0:0] {
        OP_UPDATE,
        OP_CLEAR
    } cpvc_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_V_KI,
        ST_V_KP,
        ST_V_OUT,
        ST_I_ERR,
        ST_I_KI,
        ST_I_KP,
        ST_I_OUT,
        ST_CLR
    } cpvc_state_t;

    typedef struct packed {
        cpvc_op_t                  operation;
        logic signed [DATA_W-1:0]  voltage_set;
        logic signed [DATA_W-1:0]  voltage_meas;
        logic signed [DATA_W-1:0]  current_meas;
    } cpvc_cmd_t;

    typedef struct packed {
        logic        [DATA_W-1:0]  duty;
        logic signed [DATA_W-1:0]  current_ref;
    } cpvc_res_t;

    typedef struct packed {
        logic        [GAIN_W-1:0]  kp_voltage;
        logic        [GAIN_W-1:0]  ki_dt_voltage;
        logic        [GAIN_W-1:0]  kp_current;
        logic        [GAIN_W-1:0]  ki_dt_current;
        logic signed [DATA_W-1:0]  ref_min;
        logic signed [DATA_W-1:0]  ref_max;
        logic        [DATA_W-1:0]  duty_min;
        logic        [DATA_W-1:0]  duty_max;
    } cpvc_cfg_t;

    // Sequencer to datapath controls
    typedef struct packed {
        logic load;      // capture input word, form outer error
        logic inner;     // select inner loop gains, limits and integral
        logic sel_kp;    // multiply by kp instead of ki*dt
        logic mul_en;    // register the shared multiplier product
        logic int_wr;    // write clamped integral
        logic cref_wr;   // register clamped current reference
        logic err_i_wr;  // form inner error
        logic clr;       // zero both integrals
    } cpvc_ctrl_t;

endpackage

@@ src/cpvc_datapath.sv @@
// Shared multiplier and add/clamp unit of the two PI loops, with their state.
module cpvc_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cpvc_pkg::cpvc_cfg_t  cfg,
    input  cpvc_pkg::cpvc_ctrl_t ctrl,
    input  cpvc_pkg::cpvc_cmd_t  cmd,
    output cpvc_pkg::cpvc_res_t  res
);
    import cpvc_pkg::*;

    localparam int ERR_W  = DATA_W + 1;
    localparam int PROD_W = ERR_W + GAIN_W + 1;
    localparam int INT_W  = DATA_W + FRAC_BITS + 1;
    localparam int SUM_W  = ((PROD_W > INT_W) ? PROD_W : INT_W) + 1;
    localparam int Q_W    = SUM_W - FRAC_BITS;

    logic signed [ERR_W-1:0]  err_reg;
    logic signed [DATA_W-1:0] imeas_reg;
    logic signed [DATA_W-1:0] cref_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [INT_W-1:0]  integ_v_reg;
    logic signed [INT_W-1:0]  integ_i_reg;

    logic        [GAIN_W-1:0] gain;
    logic signed [PROD_W-1:0] mul;
    logic signed [ERR_W-1:0]  lim_lo;
    logic signed [ERR_W-1:0]  lim_hi;
    logic signed [INT_W-1:0]  integ_sel;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  lo_fix;
    logic signed [SUM_W-1:0]  hi_fix;
    logic signed [SUM_W-1:0]  int_clamp;
    logic signed [Q_W-1:0]    q_trunc;
    logic signed [Q_W-1:0]    q;
    logic signed [Q_W-1:0]    lo_q;
    logic signed [Q_W-1:0]    hi_q;
    logic                     round_up;
    logic signed [ERR_W-1:0]  out_val;

    always_comb
    begin
        if (ctrl.inner)
        begin
            gain   = ctrl.sel_kp ? cfg.kp_current : cfg.ki_dt_current;
            lim_lo = $signed({1'b0, cfg.duty_min});
            lim_hi = $signed({1'b0, cfg.duty_max});
            integ_sel = integ_i_reg;
        end
        else
        begin
            gain   = ctrl.sel_kp ? cfg.kp_voltage : cfg.ki_dt_voltage;
            lim_lo = ERR_W'(cfg.ref_min);
            lim_hi = ERR_W'(cfg.ref_max);
            integ_sel = integ_v_reg;
        end
    end

    assign mul = err_reg * $signed({1'b0, gain});

    // Shared add: integral plus registered product
    assign sum    = SUM_W'(integ_sel) + SUM_W'(prod_reg);
    assign lo_fix = SUM_W'(lim_lo) <<< FRAC_BITS;
    assign hi_fix = SUM_W'(lim_hi) <<< FRAC_BITS;

    always_comb
    begin
        if (sum > hi_fix)
            int_clamp = hi_fix;
        else if (sum < lo_fix)
            int_clamp = lo_fix;
        else
            int_clamp = sum;
    end

    // Truncate toward zero: bump a negative quotient that lost fraction bits
    assign q_trunc  = Q_W'(sum >>> FRAC_BITS);
    assign round_up = sum[SUM_W-1] && (sum[FRAC_BITS-1:0] != '0);
    assign q        = round_up ? q_trunc + Q_W'(1) : q_trunc;
    assign lo_q     = Q_W'(lim_lo);
    assign hi_q     = Q_W'(lim_hi);

    always_comb
    begin
        if (q > hi_q)
            out_val = lim_hi;
        else if (q < lo_q)
            out_val = lim_lo;
        else
            out_val = q[ERR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            err_reg   <= ERR_W'(cmd.voltage_set) - ERR_W'(cmd.voltage_meas);
            imeas_reg <= cmd.current_meas;
        end
        else if (ctrl.err_i_wr)
        begin
            err_reg <= ERR_W'(cref_reg) - ERR_W'(imeas_reg);
        end
        if (ctrl.mul_en)
            prod_reg <= mul;
        if (ctrl.cref_wr)
            cref_reg <= out_val[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_v_reg <= '0;
            integ_i_reg <= '0;
        end
        else if (ctrl.clr)
        begin
            integ_v_reg <= '0;
            integ_i_reg <= '0;
        end
        else if (ctrl.int_wr)
        begin
            if (ctrl.inner)
                integ_i_reg <= INT_W'(int_clamp);
            else
                integ_v_reg <= INT_W'(int_clamp);
        end
    end

    assign res.duty        = out_val[DATA_W-1:0];
    assign res.current_ref = cref_reg;

endmodule

@@ src/cascaded_pi_voltage_current_control.sv @@
// Top level of the cascaded PI voltage/current controller.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+--------------------------------------
//  cmd     | in        | cmd_valid/cmd_stall  | operation, voltage_set/meas, current_meas
//  res     | out       | res_valid/res_stall  | duty, current_ref
//  cfg     | in        | APB psel/penable     | gains and limits, 32 bit data
//
// An update word holds the block for the accept cycle plus seven steps, in which
// one shared multiplier and one shared add/clamp unit are stepped through the
// ki*dt product, the integral update, the kp product and the output clamp of each
// loop in turn; the result register loads in the last step. A clear word loads
// it in its single clear step, and no new word is taken until the last one is done.
// cmd_stall is high from the cycle after acceptance until the result is
// loaded; the result register holds a finished word while res_stall is high,
// and the block waits in its last step until that register frees up.
// Reset clears the gains, limits, both integrals and all handshake state.
module cascaded_pi_voltage_current_control #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cpvc_pkg::APB_AW-1:0]     paddr,
    input  logic [cpvc_pkg::APB_DW-1:0]     pwdata,
    output logic [cpvc_pkg::APB_DW-1:0]     prdata,
    output logic                            pready,
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  cpvc_pkg::cpvc_cmd_t             cmd_word,
    output logic                            res_valid,
    input  logic                            res_stall,
    output cpvc_pkg::cpvc_res_t             res_word
);
    import cpvc_pkg::*;

    cpvc_cfg_t   cfg_reg;
    cpvc_reg_t   reg_idx;
    logic        cfg_wr;

    cpvc_state_t state_reg;
    cpvc_state_t state_next;
    cpvc_ctrl_t  ctrl;
    cpvc_res_t   dp_res;

    logic        res_valid_reg;
    logic        res_valid_next;
    cpvc_res_t   res_word_reg;
    logic        out_free;
    logic        res_load;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = cpvc_reg_t'(paddr[APB_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_KP_V:     cfg_reg.kp_voltage    <= pwdata[GAIN_W-1:0];
                REG_KI_V:     cfg_reg.ki_dt_voltage <= pwdata[GAIN_W-1:0];
                REG_KP_I:     cfg_reg.kp_current    <= pwdata[GAIN_W-1:0];
                REG_KI_I:     cfg_reg.ki_dt_current <= pwdata[GAIN_W-1:0];
                REG_REF_MIN:  cfg_reg.ref_min       <= pwdata[DATA_W-1:0];
                REG_REF_MAX:  cfg_reg.ref_max       <= pwdata[DATA_W-1:0];
                REG_DUTY_MIN: cfg_reg.duty_min      <= pwdata[DATA_W-1:0];
                REG_DUTY_MAX: cfg_reg.duty_max      <= pwdata[DATA_W-1:0];
                default:      cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Read back raw register bits, zero extended
    always_comb
    begin
        unique case (reg_idx)
            REG_KP_V:     prdata = APB_DW'(cfg_reg.kp_voltage);
            REG_KI_V:     prdata = APB_DW'(cfg_reg.ki_dt_voltage);
            REG_KP_I:     prdata = APB_DW'(cfg_reg.kp_current);
            REG_KI_I:     prdata = APB_DW'(cfg_reg.ki_dt_current);
            REG_REF_MIN:  prdata = APB_DW'($unsigned(cfg_reg.ref_min));
            REG_REF_MAX:  prdata = APB_DW'($unsigned(cfg_reg.ref_max));
            REG_DUTY_MIN: prdata = APB_DW'(cfg_reg.duty_min);
            REG_DUTY_MAX: prdata = APB_DW'(cfg_reg.duty_max);
            default:      prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    // The last step of either word may write the result register only when
    // it is empty or being drained this cycle.
    assign out_free = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                    state_next = (cmd_word.operation == OP_CLEAR) ? ST_CLR : ST_V_KI;
            end
            ST_V_KI:  state_next = ST_V_KP;
            ST_V_KP:  state_next = ST_V_OUT;
            ST_V_OUT: state_next = ST_I_ERR;
            ST_I_ERR: state_next = ST_I_KI;
            ST_I_KI:  state_next = ST_I_KP;
            ST_I_KP:  state_next = ST_I_OUT;
            ST_I_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_CLR:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Step controls: ki*dt product, then integral update alongside the kp
    // product, then output clamp, for the outer and then the inner loop.
    always_comb
    begin
        ctrl     = '0;
        res_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.load = cmd_valid && (cmd_word.operation == OP_UPDATE);
            end
            ST_V_KI:
            begin
                ctrl.mul_en = 1'b1;
            end
            ST_V_KP:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.sel_kp = 1'b1;
                ctrl.int_wr = 1'b1;
            end
            ST_V_OUT:
            begin
                ctrl.cref_wr = 1'b1;
            end
            ST_I_ERR:
            begin
                ctrl.err_i_wr = 1'b1;
            end
            ST_I_KI:
            begin
                ctrl.inner  = 1'b1;
                ctrl.mul_en = 1'b1;
            end
            ST_I_KP:
            begin
                ctrl.inner  = 1'b1;
                ctrl.mul_en = 1'b1;
                ctrl.sel_kp = 1'b1;
                ctrl.int_wr = 1'b1;
            end
            ST_I_OUT:
            begin
                ctrl.inner = 1'b1;
                res_load   = out_free;
            end
            ST_CLR:
            begin
                ctrl.clr = 1'b1;
                res_load = out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    assign cmd_stall = (state_reg != ST_IDLE);

    cpvc_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .ctrl  (ctrl),
        .cmd   (cmd_word),
        .res   (dp_res)
    );

    // ---------------- result register ----------------
    always_comb
    begin
        if (res_load)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    // Load zeros for a clear word, else the inner clamp and held reference
    always_ff @(posedge clk)
    begin
        if (res_load)
            res_word_reg <= (state_reg == ST_CLR) ? '0 : dp_res;
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule

@@ src/cpvc_checker.sv @@
// Port-level assertions of the cascaded PI controller and their binding.
module cpvc_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  logic                 cmd_stall,
    input  logic                 res_valid,
    input  logic                 res_stall,
    input  cpvc_pkg::cpvc_res_t  res_word
);
    import cpvc_pkg::*;

    // A stalled result word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_word))
        else $error("result word changed under stall");

    // An accepted word keeps the block busy for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("block ready right after accepting a word");

    // A fresh result only appears as a busy period ends
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(cmd_stall))
        else $error("result without a word in progress");

    // Leaving the busy period always presents a result
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(cmd_stall) |-> res_valid)
        else $error("block went ready without a result");

endmodule

bind cascaded_pi_voltage_current_control cpvc_checker u_cpvc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
);
